@@ rtl/core/tgc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types and constants for the touch gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

    localparam int COORD_BITS_DEF = 9;

    // Config register field widths and the timestamp width
    localparam int PX_W = 9;
    localparam int MS_W = 16;
    localparam int TIME_W = 32;

    // Widths used to compare coordinates and squared distances
    localparam int CMP_W = 16;
    localparam int SQ_CMP_W = 32;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PX_W-1:0] SWIPE_MIN_RST = 9'd40;
    localparam logic [MS_W-1:0] SWIPE_MAX_RST = 16'd800;
    localparam logic [MS_W-1:0] LONG_HOLD_RST = 16'd900;
    localparam logic [PX_W-1:0] BANNER_H_RST = 9'd46;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWIPE_MIN = 2'd0,
        CFG_SWIPE_MAX = 2'd1,
        CFG_LONG_HOLD = 2'd2,
        CFG_BANNER_H  = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_TOGGLE = 3'd1,
        ACT_REPLAY = 3'd2,
        ACT_NEXT   = 3'd3,
        ACT_PREV   = 3'd4,
        ACT_PAUSE  = 3'd5,
        ACT_STEP   = 3'd6
    } action_t;

    typedef struct packed {
        logic [PX_W-1:0] swipe_travel;
        logic [MS_W-1:0] swipe_window;
        logic [MS_W-1:0] hold_time;
        logic [PX_W-1:0] banner_height_px;
    } tgc_cfg_t;

    typedef struct packed {
        logic    true_time_now;
        logic    paused_now;
        action_t action;
    } tgc_result_t;

    localparam int RESULT_W = $bits(tgc_result_t);
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage
`default_nettype wire

@@ rtl/core/tgc_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_cfg
// Configuration register file: thresholds for swipe, hold and banner.
// ----------------------------------------------------------------------------
module tgc_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tgc_pkg::CFG_DATA_W-1:0] cfg_data,
    output tgc_pkg::tgc_cfg_t                   cfg
);
    import tgc_pkg::*;

    tgc_cfg_t cfg_reg;
    tgc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SWIPE_MIN: cfg_next.swipe_travel = cfg_data[PX_W-1:0];
                CFG_SWIPE_MAX: cfg_next.swipe_window = cfg_data[MS_W-1:0];
                CFG_LONG_HOLD: cfg_next.hold_time = cfg_data[MS_W-1:0];
                CFG_BANNER_H:  cfg_next.banner_height_px = cfg_data[PX_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.swipe_travel     <= SWIPE_MIN_RST;
            cfg_reg.swipe_window     <= SWIPE_MAX_RST;
            cfg_reg.hold_time        <= LONG_HOLD_RST;
            cfg_reg.banner_height_px <= BANNER_H_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/tgc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_core
// Gesture tracking and release classification; one sample per step.
// ----------------------------------------------------------------------------
module tgc_core #(
    parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       step_en,
    input  wire logic                       touched,
    input  wire logic [COORD_BITS-1:0]      touch_x,
    input  wire logic [COORD_BITS-1:0]      touch_y,
    input  wire logic [tgc_pkg::TIME_W-1:0] now_ms,
    input  wire tgc_pkg::tgc_cfg_t          cfg,
    output tgc_pkg::tgc_result_t            result
);
    import tgc_pkg::*;

    localparam int SQ_W = 2 * COORD_BITS;

    // Tracking state
    logic                  was_touched_reg, was_touched_next;
    logic [COORD_BITS-1:0] press_x_reg, press_x_next;
    logic [COORD_BITS-1:0] press_y_reg, press_y_next;
    logic [TIME_W-1:0]     press_time_reg, press_time_next;
    logic signed [COORD_BITS:0] max_move_x_reg, max_move_x_next;
    logic [SQ_W:0]         max_dist_sq_reg, max_dist_sq_next;
    logic                  in_banner_reg, in_banner_next;
    logic                  paused_reg, paused_next;
    logic                  time_mode_reg, time_mode_next;
    tgc_result_t           result_reg, result_next;

    // Datapath
    logic signed [COORD_BITS:0] dx, dy, neg_dx, neg_dy, neg_max;
    logic [COORD_BITS-1:0] ax, ay, amax;
    logic [SQ_W-1:0]       sq_x, sq_y;
    logic [SQ_W:0]         d2;
    logic [2*PX_W-1:0]     lim_sq;
    logic [TIME_W-1:0]     held;
    logic [CMP_W-1:0]      y_ext, banner_ext, amax_ext, lim_ext;
    logic [TIME_W-1:0]     long_ext, swipe_ext;
    logic [SQ_CMP_W-1:0]   dist_ext, lim_sq_ext;
    logic                  is_long, is_swipe, is_tap;
    action_t               action;

    assign dx = signed'({1'b0, touch_x}) - signed'({1'b0, press_x_reg});
    assign dy = signed'({1'b0, touch_y}) - signed'({1'b0, press_y_reg});
    assign neg_dx = -dx;
    assign neg_dy = -dy;
    assign neg_max = -max_move_x_reg;
    assign ax = dx[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign ay = dy[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    assign amax = max_move_x_reg[COORD_BITS] ? neg_max[COORD_BITS-1:0]
                                             : max_move_x_reg[COORD_BITS-1:0];
    assign sq_x = ax * ax;
    assign sq_y = ay * ay;
    assign d2 = {1'b0, sq_x} + {1'b0, sq_y};
    assign lim_sq = cfg.swipe_travel * cfg.swipe_travel;

    assign held = now_ms - press_time_reg;

    assign y_ext = {{(CMP_W-COORD_BITS){1'b0}}, touch_y};
    assign banner_ext = {{(CMP_W-PX_W){1'b0}}, cfg.banner_height_px};
    assign amax_ext = {{(CMP_W-COORD_BITS){1'b0}}, amax};
    assign lim_ext = {{(CMP_W-PX_W){1'b0}}, cfg.swipe_travel};
    assign long_ext = {{(TIME_W-MS_W){1'b0}}, cfg.hold_time};
    assign swipe_ext = {{(TIME_W-MS_W){1'b0}}, cfg.swipe_window};
    assign dist_ext = {{(SQ_CMP_W-SQ_W-1){1'b0}}, max_dist_sq_reg};
    assign lim_sq_ext = {{(SQ_CMP_W-2*PX_W){1'b0}}, lim_sq};

    assign is_long = held >= long_ext;
    assign is_swipe = (amax_ext >= lim_ext) && (held <= swipe_ext);
    assign is_tap = dist_ext < lim_sq_ext;

    always_comb begin
        was_touched_next = was_touched_reg;
        press_x_next = press_x_reg;
        press_y_next = press_y_reg;
        press_time_next = press_time_reg;
        max_move_x_next = max_move_x_reg;
        max_dist_sq_next = max_dist_sq_reg;
        in_banner_next = in_banner_reg;
        paused_next = paused_reg;
        time_mode_next = time_mode_reg;
        action = ACT_NONE;
        result_next = result_reg;

        if (step_en) begin
            was_touched_next = touched;
            if (touched && !was_touched_reg) begin
                // Press edge: latch origin and clear the extremes
                press_x_next = touch_x;
                press_y_next = touch_y;
                press_time_next = now_ms;
                max_move_x_next = '0;
                max_dist_sq_next = '0;
                in_banner_next = y_ext < banner_ext;
            end else if (touched) begin
                // Equal magnitude keeps the earlier move
                if (ax > amax) begin
                    max_move_x_next = dx;
                end
                if (d2 > max_dist_sq_reg) begin
                    max_dist_sq_next = d2;
                end
            end else if (was_touched_reg) begin
                if (is_long) begin
                    if (in_banner_reg) begin
                        time_mode_next = !time_mode_reg;
                        action = ACT_TOGGLE;
                    end else begin
                        paused_next = 1'b0;
                        action = ACT_REPLAY;
                    end
                end else if (is_swipe) begin
                    paused_next = 1'b0;
                    action = max_move_x_reg[COORD_BITS] ? ACT_NEXT : ACT_PREV;
                end else if (is_tap) begin
                    if (!paused_reg) begin
                        paused_next = 1'b1;
                        action = ACT_PAUSE;
                    end else begin
                        action = ACT_STEP;
                    end
                end
            end
            result_next.action = action;
            result_next.paused_now = paused_next;
            result_next.true_time_now = time_mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_touched_reg <= 1'b0;
            in_banner_reg <= 1'b0;
            paused_reg <= 1'b0;
            time_mode_reg <= 1'b0;
        end else begin
            was_touched_reg <= was_touched_next;
            in_banner_reg <= in_banner_next;
            paused_reg <= paused_next;
            time_mode_reg <= time_mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        press_x_reg <= press_x_next;
        press_y_reg <= press_y_next;
        press_time_reg <= press_time_next;
        max_move_x_reg <= max_move_x_next;
        max_dist_sq_reg <= max_dist_sq_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule
`default_nettype wire

@@ rtl/core/touch_gesture_classifier.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// Tap / swipe / long-hold detector over a stream of touch samples.
// ----------------------------------------------------------------------------
// Every accepted sample produces exactly one result beat: an action code plus
// the paused and time-mode flags as they stand after that sample. A sample is
// captured in the input register when accepted and classified into the result
// register once that register is free or its beat is being taken, which raises
// m_tvalid. The block takes one sample every cycle; the single classify stage
// between the two registers sets that rate, and it stalls only when the result
// register is full and not being taken. Config writes complete in the cycle
// they are presented and should be issued while no samples are in flight.
module touch_gesture_classifier #(
    parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Sample stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // tdata: touch_x, touch_y, now_ms (from bit 0 up), zero padded to bytes
    input  wire logic [((2*COORD_BITS+tgc_pkg::TIME_W+7)/8)*8-1:0] s_tdata,
    // tuser: touched
    input  wire logic                               s_tuser,
    // Result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // tdata: action[2:0], paused_now, true_time_now (from bit 0 up), zero pad
    output logic [tgc_pkg::M_TDATA_W-1:0]           m_tdata,
    // Config write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tgc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tgc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tgc_pkg::*;

    localparam int Y_LSB = COORD_BITS;
    localparam int T_LSB = 2 * COORD_BITS;

    logic                  in_valid_reg, in_valid_next;
    logic                  touched_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [TIME_W-1:0]     now_reg;
    logic                  m_valid_reg, m_valid_next;
    logic                  advance;
    logic                  s_fire;
    tgc_cfg_t              cfg;
    tgc_result_t           result;

    // Move the held sample into the result stage when that stage is free or its beat is being taken
    assign advance = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire = s_tvalid && s_tready;

    assign in_valid_next = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign m_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the beat
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            touched_reg <= s_tuser;
            x_reg <= s_tdata[COORD_BITS-1:0];
            y_reg <= s_tdata[Y_LSB +: COORD_BITS];
            now_reg <= s_tdata[T_LSB +: TIME_W];
        end
    end

    tgc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tgc_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .touched (touched_reg),
        .touch_x (x_reg),
        .touch_y (y_reg),
        .now_ms  (now_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {{(M_TDATA_W-RESULT_W){1'b0}}, result.true_time_now,
                      result.paused_now, result.action};

endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the touch gesture classifier. Touch samples go in as
// directed gestures, then random taps, swipes, long holds and noise across
// several register settings. A local gesture model predicts one result beat
// per sample, and each result beat is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
    import tgc_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int PX_MAX = (1 << CB) - 1;
    localparam int S_W = ((2 * CB + TIME_W + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int SQUEEZE_CYCLES = 300;

    typedef struct {
        logic          touched;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [31:0]   now;
    } sample_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    touch_gesture_classifier #(.COORD_BITS(CB)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    sample_t     sample_q[$];
    tgc_result_t result_q[$];
    int          errors = 0;
    int          results_seen = 0;
    bit          s_fire = 1'b0;
    bit          m_fire = 1'b0;
    bit          c_fire = 1'b0;

    // gesture model state and its copy of the registers
    logic [PX_W-1:0]   g_swipe_min = SWIPE_MIN_RST;
    logic [MS_W-1:0]   g_swipe_max = SWIPE_MAX_RST;
    logic [MS_W-1:0]   g_long_hold = LONG_HOLD_RST;
    logic [PX_W-1:0]   g_banner_h = BANNER_H_RST;
    logic              g_down = 1'b0;
    logic [CB-1:0]     g_press_x = '0;
    logic [CB-1:0]     g_press_y = '0;
    logic [31:0]       g_press_t = '0;
    logic signed [CB:0] g_peak_dx = '0;
    logic [19:0]       g_peak_d2 = '0;
    logic              g_in_banner = 1'b0;
    logic              g_paused = 1'b0;
    logic              g_true_time = 1'b0;

    // generator's view of the current setting
    int          gen_min = SWIPE_MIN_RST;
    int          gen_smax = SWIPE_MAX_RST;
    int          gen_lhold = LONG_HOLD_RST;
    int          gen_banner = BANNER_H_RST;
    logic [31:0] gen_clock = 32'd10000;
    int          gen_count = 0;

    function automatic int iabs(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clamp_px(input int v);
        return (v < 0) ? 0 : ((v > PX_MAX) ? PX_MAX : v);
    endfunction

    task automatic classify_sample(input sample_t smp, output tgc_result_t res);
        int          dx;
        int          dy;
        int          ax;
        int          ay;
        int          lim;
        logic [31:0] held;
        action_t     act;
        act = ACT_NONE;
        if (smp.touched && !g_down) begin
            g_press_x = smp.x;
            g_press_y = smp.y;
            g_press_t = smp.now;
            g_peak_dx = '0;
            g_peak_d2 = '0;
            g_in_banner = ({1'b0, smp.y} < {1'b0, g_banner_h});
        end else if (smp.touched) begin
            dx = int'(smp.x) - int'(g_press_x);
            dy = int'(smp.y) - int'(g_press_y);
            ax = iabs(dx);
            ay = iabs(dy);
            // strictly larger only: an equal magnitude keeps the older move
            if (ax > iabs(int'(g_peak_dx)))
                g_peak_dx = dx[CB:0];
            if (ax * ax + ay * ay > int'(g_peak_d2))
                g_peak_d2 = 20'(ax * ax + ay * ay);
        end else if (g_down) begin
            held = smp.now - g_press_t;
            lim = int'(g_swipe_min);
            if (held >= {16'd0, g_long_hold}) begin
                if (g_in_banner) begin
                    g_true_time = ~g_true_time;
                    act = ACT_TOGGLE;
                end else begin
                    g_paused = 1'b0;
                    act = ACT_REPLAY;
                end
            end else if (iabs(int'(g_peak_dx)) >= lim && held <= {16'd0, g_swipe_max}) begin
                g_paused = 1'b0;
                act = (g_peak_dx < 0) ? ACT_NEXT : ACT_PREV;
            end else if (int'(g_peak_d2) < lim * lim) begin
                act = g_paused ? ACT_STEP : ACT_PAUSE;
                g_paused = 1'b1;
            end
        end
        g_down = smp.touched;
        res.action = act;
        res.paused_now = g_paused;
        res.true_time_now = g_true_time;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // ---- acceptance, prediction and checking, all sampled at the rising edge
    always @(posedge aclk) begin
        tgc_result_t want;
        tgc_result_t got;
        sample_t     smp;
        s_fire = aresetn && s_tvalid && s_tready;
        m_fire = aresetn && m_tvalid && m_tready;
        c_fire = aresetn && cfg_valid && cfg_ready;
        if (c_fire) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SWIPE_MIN: g_swipe_min = cfg_data[PX_W-1:0];
                CFG_SWIPE_MAX: g_swipe_max = cfg_data[MS_W-1:0];
                CFG_LONG_HOLD: g_long_hold = cfg_data[MS_W-1:0];
                CFG_BANNER_H:  g_banner_h = cfg_data[PX_W-1:0];
                default: ;
            endcase
        end
        if (m_fire) begin
            results_seen++;
            got.action = action_t'(m_tdata[2:0]);
            got.paused_now = m_tdata[3];
            got.true_time_now = m_tdata[4];
            if (result_q.size() == 0) begin
                report_mismatch("result beat with nothing pending, action", got.action, 0);
            end else begin
                want = result_q.pop_front();
                if (got.action !== want.action)
                    report_mismatch("action", got.action, want.action);
                if (got.paused_now !== want.paused_now)
                    report_mismatch("paused_now", got.paused_now, want.paused_now);
                if (got.true_time_now !== want.true_time_now)
                    report_mismatch("true_time_now", got.true_time_now, want.true_time_now);
            end
        end
        if (s_fire) begin
            smp.touched = s_tuser;
            smp.x = s_tdata[CB-1:0];
            smp.y = s_tdata[2*CB-1:CB];
            smp.now = s_tdata[2*CB+TIME_W-1:2*CB];
            classify_sample(smp, want);
            result_q.push_back(want);
        end
    end

    // ---- watchdog: end the run when nothing moves for too long
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if (s_fire || m_fire || c_fire || !aresetn)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---- sample driver
    int s_wait = 0;
    bit s_burst = 1'b0;
    always @(negedge aclk) begin
        sample_t smp;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fire) begin
            // hold the beat until taken
        end else if (s_wait > 0) begin
            s_tvalid <= 1'b0;
            s_wait--;
        end else if (sample_q.size() > 0) begin
            smp = sample_q.pop_front();
            s_tvalid <= 1'b1;
            s_tuser <= smp.touched;
            s_tdata <= {{(S_W-2*CB-TIME_W){1'b0}}, smp.now, smp.y, smp.x};
            if ($urandom_range(0, 19) == 0)
                s_burst = ~s_burst;
            s_wait = s_burst ? 0 : $urandom_range(0, 6);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // ---- result receiver, with one long hold-off to back the block up
    int m_wait = 0;
    bit m_burst = 1'b0;
    int squeeze_left = 0;
    bit squeeze_done = 1'b0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_fire) begin
                if ($urandom_range(0, 19) == 0)
                    m_burst = ~m_burst;
                m_wait = m_burst ? 0 : $urandom_range(0, 6);
            end
            if (!squeeze_done && results_seen >= 300 && sample_q.size() > 40) begin
                squeeze_left = SQUEEZE_CYCLES;
                squeeze_done = 1'b1;
            end
            if (squeeze_left > 0) begin
                m_tready <= 1'b0;
                squeeze_left--;
            end else if (m_wait > 0) begin
                m_tready <= 1'b0;
                m_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---- stimulus helpers
    task automatic add_sample(input bit touched, input int x, input int y,
                              input logic [31:0] now);
        sample_t smp;
        smp.touched = touched;
        smp.x = x[CB-1:0];
        smp.y = y[CB-1:0];
        smp.now = now;
        sample_q.push_back(smp);
        gen_count++;
    endtask

    task automatic add_gesture();
        int          px;
        int          py;
        int          mv;
        int          dy;
        int          tx;
        int          ty;
        int          held;
        int          drags;
        logic [31:0] t0;
        px = $urandom_range(0, PX_MAX);
        if ($urandom_range(0, 2) == 0)
            py = clamp_px($urandom_range(0, clamp_px(gen_banner + 1)));
        else
            py = $urandom_range(0, PX_MAX);
        case ($urandom_range(0, 3))
            0: mv = gen_min - 1 + $urandom_range(0, 2);
            1: mv = $urandom_range(0, gen_min);
            2: mv = $urandom_range(0, PX_MAX);
            default: mv = 0;
        endcase
        if (mv < 0)
            mv = 0;
        tx = clamp_px($urandom_range(0, 1) ? px + mv : px - mv);
        dy = $urandom_range(0, 1) ? $urandom_range(0, gen_min / 2 + 1)
                                  : $urandom_range(0, PX_MAX);
        ty = clamp_px($urandom_range(0, 1) ? py + dy : py - dy);
        case ($urandom_range(0, 4))
            0: held = $urandom_range(0, gen_smax);
            1: held = gen_smax - 1 + $urandom_range(0, 2);
            2: held = gen_lhold - 1 + $urandom_range(0, 2);
            3: held = $urandom_range(0, 2 * gen_lhold);
            default: held = $urandom_range(0, 60);
        endcase
        if (held < 0)
            held = 0;
        t0 = gen_clock;
        add_sample(1'b1, px, py, t0);
        drags = $urandom_range(0, 4);
        for (int i = 0; i < drags; i++) begin
            if (i == drags - 1)
                add_sample(1'b1, tx, ty, t0 + held * (i + 1) / (drags + 1));
            else
                add_sample(1'b1, clamp_px(px + $urandom_range(0, 2 * mv) - mv),
                           clamp_px(py + $urandom_range(0, 2 * dy) - dy),
                           t0 + held * (i + 1) / (drags + 1));
        end
        // now and then drop the release so the next press can land as a drag
        if ($urandom_range(0, 19) != 0)
            add_sample(1'b0, $urandom_range(0, PX_MAX), $urandom_range(0, PX_MAX), t0 + held);
        gen_clock = t0 + held + $urandom_range(1, 50);
        case ($urandom_range(0, 15))
            0: gen_clock = $urandom();
            1: gen_clock = 32'hFFFF_FFFF - $urandom_range(0, 1000);
            default: ;
        endcase
    endtask

    task automatic add_random(input int n);
        int stop;
        stop = gen_count + n;
        while (gen_count < stop) begin
            if ($urandom_range(0, 9) == 0) begin
                add_sample($urandom_range(0, 1), $urandom_range(0, PX_MAX),
                           $urandom_range(0, PX_MAX), $urandom());
            end else begin
                repeat ($urandom_range(0, 2))
                    add_sample(1'b0, $urandom_range(0, PX_MAX), $urandom_range(0, PX_MAX),
                               gen_clock);
                add_gesture();
            end
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        do
            @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (sample_q.size() != 0 || result_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_setting(input int smin, input int smax, input int lhold,
                               input int banner, input int n);
        write_reg(CFG_SWIPE_MIN, smin);
        write_reg(CFG_SWIPE_MAX, smax);
        write_reg(CFG_LONG_HOLD, lhold);
        write_reg(CFG_BANNER_H, banner);
        gen_min = smin;
        gen_smax = smax;
        gen_lhold = lhold;
        gen_banner = banner;
        add_random(n);
        wait_drain();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed gestures under the reset setting
        add_sample(1'b0, PX_MAX, PX_MAX, 32'hFFFF_FFFF);         // no contact at all
        add_sample(1'b1, 0, 0, 32'd100);                          // banner press
        add_sample(1'b0, 0, 0, 32'd1000);                         // long hold: toggle
        add_sample(1'b1, PX_MAX, PX_MAX, 32'd2000);
        add_sample(1'b1, 0, PX_MAX, 32'd2400);                    // full left drag
        add_sample(1'b0, 0, 0, 32'd2800);                         // next beat at limit
        add_sample(1'b1, 100, 200, 32'd3000);
        add_sample(1'b1, 140, 200, 32'd3100);
        add_sample(1'b1, 60, 200, 32'd3200);                      // equal magnitude kept
        add_sample(1'b0, 0, 0, 32'd3300);                         // previous beat
        add_sample(1'b1, 200, 200, 32'd4000);
        add_sample(1'b1, 210, 210, 32'd4050);
        add_sample(1'b0, PX_MAX, 0, 32'd4100);                    // tap: pause
        add_sample(1'b1, 200, 200, 32'd4200);
        add_sample(1'b0, 9, 9, 32'd4250);                         // tap again: step
        add_sample(1'b1, 300, 300, 32'd5000);
        add_sample(1'b0, 0, 0, 32'd5900);                         // replay, resume
        add_sample(1'b1, 100, 100, 32'd6000);
        add_sample(1'b1, 200, 100, 32'd6100);
        add_sample(1'b0, 0, 0, 32'd6850);                         // too slow: none
        add_sample(1'b1, 50, 46, 32'd7000);
        add_sample(1'b0, 0, 0, 32'd7900);                         // just below banner
        add_sample(1'b1, 50, 45, 32'd8000);
        add_sample(1'b0, 0, 0, 32'd8900);                         // in banner
        add_sample(1'b1, 20, 20, 32'hFFFF_FF00);
        add_sample(1'b0, 0, 0, 32'h0000_0100);                    // wrapped timestamp
        add_random(130);
        wait_drain();

        run_setting(1, 65535, 65535, PX_MAX, 140);
        run_setting(PX_MAX, 1, 1, 0, 140);
        run_setting(0, 300, 600, 100, 140);
        run_setting(25, 500, 700, 300, 140);
        run_setting(SWIPE_MIN_RST, SWIPE_MAX_RST, LONG_HOLD_RST, BANNER_H_RST, 140);

        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ touch_gesture_classifier.f @@
rtl/core/tgc_pkg.sv
rtl/core/tgc_cfg.sv
rtl/core/tgc_core.sv
rtl/core/touch_gesture_classifier.sv
test/tb.sv
